### rtl/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk_i edge, off while rst_ni is low
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be true
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

### rtl/pmrd_pkg.sv
// package: widths, controller states and control structs of the peer table
package pmrd_pkg;

  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned KeyW          = 48;
  localparam int unsigned LvlW          = 8;
  localparam int unsigned TotW          = 7;

  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StFlushRd,
    StFlushLd,
    StFlushEmpty
  } ctl_state_e;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic latch_in;
    logic rd_clr;
    logic issue_rd;
    logic upd_wr;
    logic app_wr;
    logic out_ld;
    logic out_empty;
    logic cnt_clr;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_flush;
    logic hit;
    logic greater;
    logic rd_more;
    logic srch_end;
    logic full;
    logic cnt_zero;
    logic last;
    logic slot_free;
  } dp_sts_t;

endpackage

### rtl/pmrd_ifs.sv
// handshake interfaces for the request and the result channel
interface pmrd_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [pmrd_pkg::KeyW-1:0]         peer_key;
  logic signed [pmrd_pkg::LvlW-1:0]  signal_level;

  modport source (output valid, req_type, peer_key, signal_level, input ready);
  modport sink   (input valid, req_type, peer_key, signal_level, output ready);
endinterface

interface pmrd_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [pmrd_pkg::KeyW-1:0]         out_peer_key;
  logic signed [pmrd_pkg::LvlW-1:0]  best_level;
  logic                              entry_valid;
  logic                              last_entry;
  logic [pmrd_pkg::TotW-1:0]         peer_total;

  modport source (output valid, out_peer_key, best_level, entry_valid, last_entry,
                  peer_total, input ready);
  modport sink   (input valid, out_peer_key, best_level, entry_valid, last_entry,
                  peer_total, output ready);
endinterface

### rtl/peer_max_rssi_dedup_table.sv
// top level: peer table that keeps the strongest level per unique peer
// usage
//   req_i carries one request beat: req_type 0 observes a peer (peer_key, signal_level),
//   req_type 1 flushes the table. rsp_o carries result beats, produced only by flushes.
//   req_i.ready is high whenever the controller is idle, also while a result beat
//   still waits in the output register for the receiver.
// search and flush
//   an observation walks the stored entries one ram read per cycle behind the registered
//   ram read; a hit or the end of the stored entries returns the controller to idle, and
//   the next request is taken only from idle
//   a flush reads the entries in order and, while the output register is free, gives one
//   result beat per cycle; a flush of an empty table gives one beat with entry_valid low
// reset
//   rst_ni clears the entry count, the controller and the output valid; the ram
//   contents are not cleared, entries are read only below the count
// stalls
//   while rsp_o.ready is low the flush holds its position in the table and resumes
//   when the output register frees; nothing is dropped or repeated
`include "assert_macros.svh"

module peer_max_rssi_dedup_table #(
  parameter int unsigned TableDepth = pmrd_pkg::TableDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pmrd_req_if.sink   req_i,
  pmrd_rsp_if.source rsp_o
);
  import pmrd_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // state machine: decides search, update, append and flush steps
  pmrd_ctl u_ctl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // storage, pointers, compare and result register
  pmrd_dp #(
    .TableDepth (TableDepth)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

  // a table write is either an in-place update or an append, never both
  `ASSERT_NEVER(a_single_wr, cmd.upd_wr && cmd.app_wr, "update and append in one cycle")

  // the final beat of a flush empties the table
  `ASSERT_CLK(a_flush_clears, (cmd.out_ld && sts.last) |=> sts.cnt_zero, "count not cleared")

  // the empty marker beat is produced only for an empty table
  `ASSERT_CLK(a_empty_beat, cmd.out_empty |-> sts.cnt_zero, "empty beat with entries held")

  // no result beat is loaded while the block takes requests
  `ASSERT_NEVER(a_idle_no_ld, req_i.ready && (cmd.out_ld || cmd.out_empty),
                "result loaded while idle")

endmodule

### rtl/pmrd_ram.sv
// generic single write port ram with registered read
module pmrd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pmrd_ctl.sv
// controller: sequences search, update, append and flush
module pmrd_ctl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pmrd_pkg::dp_sts_t  sts_i,
  output pmrd_pkg::ctl_cmd_t cmd_o
);
  import pmrd_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.latch_in = 1'b1;
          cmd_o.rd_clr   = 1'b1;
          if (!sts_i.in_flush) begin
            state_d = StSearch;
          end else if (sts_i.cnt_zero) begin
            state_d = StFlushEmpty;
          end else begin
            state_d = StFlushRd;
          end
        end
      end
      StSearch: begin
        cmd_o.issue_rd = sts_i.rd_more;
        if (sts_i.hit) begin
          cmd_o.upd_wr = sts_i.greater;
          state_d      = StIdle;
        end else if (sts_i.srch_end) begin
          cmd_o.app_wr = !sts_i.full;
          state_d      = StIdle;
        end
      end
      StFlushRd: begin
        cmd_o.issue_rd = 1'b1;
        state_d        = StFlushLd;
      end
      StFlushLd: begin
        if (sts_i.slot_free) begin
          cmd_o.out_ld = 1'b1;
          if (sts_i.last) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = StIdle;
          end else begin
            cmd_o.issue_rd = 1'b1;
          end
        end
      end
      StFlushEmpty: begin
        if (sts_i.slot_free) begin
          cmd_o.out_empty = 1'b1;
          state_d         = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

### rtl/pmrd_dp.sv
// datapath: entry count, read pointer, table ram and result register
module pmrd_dp #(
  parameter int unsigned TableDepth = pmrd_pkg::TableDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pmrd_pkg::ctl_cmd_t cmd_i,
  output pmrd_pkg::dp_sts_t  sts_o,
  pmrd_req_if.sink           req_i,
  pmrd_rsp_if.source         rsp_o
);
  import pmrd_pkg::*;

  localparam int unsigned CntW  = $clog2(TableDepth + 1);
  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned EntW  = KeyW + LvlW;

  logic [KeyW-1:0]        key_q;
  logic signed [LvlW-1:0] lvl_q;
  logic [CntW-1:0]        cnt_q, rd_idx_q, cmp_idx_q;
  logic                   rd_pend_q;
  logic [EntW-1:0]        rdata;
  logic [KeyW-1:0]        rd_key;
  logic signed [LvlW-1:0] rd_lvl;
  logic                   we;
  logic [AddrW-1:0]       waddr;

  logic                   out_vld_q;
  logic [KeyW-1:0]        out_key_q;
  logic signed [LvlW-1:0] out_lvl_q;
  logic                   out_ent_q, out_last_q;
  logic [TotW-1:0]        out_tot_q;

  assign rd_key = rdata[EntW-1:LvlW];
  assign rd_lvl = rdata[LvlW-1:0];

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      key_q <= req_i.peer_key;
      lvl_q <= req_i.signal_level;
    end
  end

  // count and read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rd_idx_q  <= '0;
      cmp_idx_q <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.issue_rd;
      if (cmd_i.rd_clr) begin
        rd_idx_q <= '0;
      end else if (cmd_i.issue_rd) begin
        rd_idx_q  <= rd_idx_q + CntW'(1);
        cmp_idx_q <= rd_idx_q;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.app_wr) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  assign we    = cmd_i.upd_wr | cmd_i.app_wr;
  assign waddr = cmd_i.upd_wr ? cmp_idx_q[AddrW-1:0] : cnt_q[AddrW-1:0];

  pmrd_ram #(
    .Width (EntW),
    .Depth (TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({key_q, lvl_q}),
    .re_i    (cmd_i.issue_rd),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_ld || cmd_i.out_empty) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_key_q  <= rd_key;
      out_lvl_q  <= rd_lvl;
      out_ent_q  <= 1'b1;
      out_last_q <= sts_o.last;
      out_tot_q  <= TotW'(cnt_q);
    end else if (cmd_i.out_empty) begin
      out_key_q  <= '0;
      out_lvl_q  <= '0;
      out_ent_q  <= 1'b0;
      out_last_q <= 1'b1;
      out_tot_q  <= '0;
    end
  end

  assign req_i.ready        = cmd_i.in_ready;
  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.out_peer_key = out_key_q;
  assign rsp_o.best_level   = out_lvl_q;
  assign rsp_o.entry_valid  = out_ent_q;
  assign rsp_o.last_entry   = out_last_q;
  assign rsp_o.peer_total   = out_tot_q;

  always_comb begin
    sts_o           = '0;
    sts_o.in_valid  = req_i.valid;
    sts_o.in_flush  = req_i.req_type;
    sts_o.rd_more   = rd_idx_q < cnt_q;
    sts_o.hit       = rd_pend_q && (rd_key == key_q);
    sts_o.greater   = lvl_q > rd_lvl;
    sts_o.srch_end  = !rd_pend_q && !sts_o.rd_more;
    sts_o.full      = cnt_q == CntW'(TableDepth);
    sts_o.cnt_zero  = cnt_q == '0;
    sts_o.last      = CntW'(cmp_idx_q + CntW'(1)) == cnt_q;
    sts_o.slot_free = !out_vld_q || rsp_o.ready;
  end

endmodule

### verif/peer_max_rssi_dedup_table_tb.sv
// testbench for the peer table: random and directed scans and flushes, checked beat by beat
`timescale 1ns / 1ps

module peer_max_rssi_dedup_table_tb;
  import pmrd_pkg::*;

  // request kinds carried in req_type
  localparam logic ReqObserve = 1'b0;
  localparam logic ReqFlush   = 1'b1;

  localparam int unsigned Depth       = TableDepthDef;
  localparam int unsigned RandomItems = 310;
  localparam int unsigned HoldCycles  = 300;
  // longer than a full-table search, so this covers any search still running
  localparam int unsigned DrainCycles = Depth + 16;

  // one result beat of a flush
  typedef struct packed {
    logic [KeyW-1:0]        key;
    logic signed [LvlW-1:0] level;
    logic                   valid;
    logic                   last;
    logic [TotW-1:0]        total;
  } flush_beat_t;

  // mirror of the peer table plus the queue of flush beats still owed by the block
  class peer_table_scoreboard;
    logic [KeyW-1:0]        peer_key_mem [Depth];
    logic signed [LvlW-1:0] peer_lvl_mem [Depth];
    int unsigned            peers_held;
    flush_beat_t            owed_beats [$];
    int unsigned errors, observations, added, raised, kept, dropped;
    int unsigned flushes, empty_flushes, beats_checked;

    function new();
      peers_held = 0;
      errors = 0; observations = 0; added = 0; raised = 0; kept = 0; dropped = 0;
      flushes = 0; empty_flushes = 0; beats_checked = 0;
    endfunction

    function int unsigned pending();
      return owed_beats.size();
    endfunction

    // update the table mirror for one accepted request beat, queue any flush beats
    function void note_request(input logic kind, input logic [KeyW-1:0] key,
                               input logic signed [LvlW-1:0] level);
      bit found;
      flush_beat_t beat;
      found = 1'b0;
      if (kind == ReqObserve) begin
        observations++;
        // first match in insertion order wins; keys are unique so there is at most one
        for (int i = 0; i < peers_held; i++) begin
          if (!found && peer_key_mem[i] == key) begin
            found = 1'b1;
            if (level > peer_lvl_mem[i]) begin
              peer_lvl_mem[i] = level;
              raised++;
            end else begin
              kept++;
            end
          end
        end
        if (!found) begin
          if (peers_held < Depth) begin
            peer_key_mem[peers_held] = key;
            peer_lvl_mem[peers_held] = level;
            peers_held++;
            added++;
          end else begin
            dropped++;
          end
        end
      end else begin
        flushes++;
        if (peers_held == 0) begin
          // empty table: a single beat marked not valid
          beat = '{key: '0, level: '0, valid: 1'b0, last: 1'b1, total: '0};
          owed_beats.push_back(beat);
          empty_flushes++;
        end else begin
          for (int i = 0; i < peers_held; i++) begin
            beat.key   = peer_key_mem[i];
            beat.level = peer_lvl_mem[i];
            beat.valid = 1'b1;
            beat.last  = (i == peers_held - 1);
            beat.total = TotW'(peers_held);
            owed_beats.push_back(beat);
          end
          peers_held = 0;
        end
      end
    endfunction

    function void compare_field(input string name, input logic [KeyW-1:0] exp_val,
                                input logic [KeyW-1:0] act_val);
      if (exp_val !== act_val) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      end
    endfunction

    // compare one accepted result beat with the oldest owed beat
    function void check_result(input flush_beat_t got);
      flush_beat_t exp_beat;
      if (owed_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual key %h level %0d",
                 $time, got.key, got.level);
        return;
      end
      exp_beat = owed_beats.pop_front();
      beats_checked++;
      compare_field("out_peer_key", exp_beat.key, got.key);
      compare_field("best_level", KeyW'(exp_beat.level), KeyW'(got.level));
      compare_field("entry_valid", KeyW'(exp_beat.valid), KeyW'(got.valid));
      compare_field("last_entry", KeyW'(exp_beat.last), KeyW'(got.last));
      compare_field("peer_total", KeyW'(exp_beat.total), KeyW'(got.total));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pmrd_req_if req_if ();
  pmrd_rsp_if rsp_if ();

  peer_max_rssi_dedup_table dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  peer_table_scoreboard sb;

  // sender pacing and the long receiver hold-off
  int unsigned burst_left;
  bit          steady;
  bit          hold_request;
  int unsigned random_sent;

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("peer_max_rssi_dedup_table test failed");
    $finish;
  end

  // every result beat is checked at the edge where it is taken
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      sb.check_result('{key: rsp_if.out_peer_key, level: rsp_if.best_level,
                        valid: rsp_if.entry_valid, last: rsp_if.last_entry,
                        total: rsp_if.peer_total});
    end
  end

  // receiver: picks a new random stall pattern whenever the current one runs out; a hold
  // request forces a long stretch with ready low, counted here
  initial begin
    int unsigned mode, left, period;
    mode = 0;
    left = 0;
    period = 2;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        rsp_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        if (left == 0) begin
          mode   = $urandom_range(0, 3);
          left   = $urandom_range(20, 120);
          period = $urandom_range(2, 5);
        end
        left--;
        case (mode)
          0: rsp_if.ready = 1'b1;
          1: rsp_if.ready = ($urandom_range(0, 9) < 7);
          2: rsp_if.ready = ((left % period) != 0);
          default: rsp_if.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [KeyW-1:0] rand_key();
    logic [63:0] word;
    word = {$urandom, $urandom};
    return word[KeyW-1:0];
  endfunction

  function automatic logic signed [LvlW-1:0] rand_level();
    logic [LvlW-1:0] raw;
    // bias toward the extremes now and then
    case ($urandom_range(0, 9))
      0: raw = 8'h80;
      1: raw = 8'h7f;
      default: raw = LvlW'($urandom_range(0, 255));
    endcase
    return raw;
  endfunction

  // sender bursts: random burst length, random gap in between, no gap in steady stretches
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        req_if.valid = 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  // offer one request beat and hold it until the block takes it
  task automatic send_req(input logic kind, input logic [KeyW-1:0] key,
                          input logic signed [LvlW-1:0] level);
    pace();
    @(negedge clk);
    req_if.valid        = 1'b1;
    req_if.req_type     = kind;
    req_if.peer_key     = key;
    req_if.signal_level = level;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(kind, key, level);
  endtask

  task automatic observe(input logic [KeyW-1:0] key, input logic signed [LvlW-1:0] level);
    send_req(ReqObserve, key, level);
    random_sent++;
  endtask

  task automatic flush();
    // key and level are don't-care on a flush, so scramble them
    send_req(ReqFlush, rand_key(), rand_level());
    random_sent++;
  endtask

  // stop offering until every owed beat has come back
  task automatic drain();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // more unique peers than the table holds, a few hits and a miss on the full table, then a flush
  task automatic fill_round();
    logic [KeyW-1:0] base;
    int unsigned extra;
    base  = rand_key();
    extra = $urandom_range(1, 8);
    for (int i = 0; i < Depth + extra; i++) observe(base ^ KeyW'(i), rand_level());
    repeat (3) observe(base ^ KeyW'($urandom_range(0, Depth - 1)), rand_level());
    observe(base ^ KeyW'(8'hf0), rand_level());
    flush();
  endtask

  // a handful of recurring peers so most observations hit
  task automatic pool_round(input bit with_flush);
    logic [KeyW-1:0] pool [16];
    int unsigned pool_size, count;
    pool_size = $urandom_range(1, 12);
    count     = $urandom_range(1, 25);
    for (int i = 0; i < pool_size; i++) pool[i] = rand_key();
    repeat (count) observe(pool[$urandom_range(0, pool_size - 1)], rand_level());
    if (with_flush) flush();
  endtask

  initial begin
    int unsigned pick;
    logic [KeyW-1:0] name_key;
    sb = new();
    burst_left   = 0;
    steady       = 1'b0;
    hold_request = 1'b0;
    random_sent  = 0;
    name_key     = 48'h414243444546;

    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.req_type     = ReqObserve;
    req_if.peer_key     = '0;
    req_if.signal_level = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty flush, extreme keys and levels, equal, weaker and stronger hits
    send_req(ReqFlush, '0, '0);
    send_req(ReqObserve, '0, -8'sd128);
    send_req(ReqObserve, '1, 8'sd127);
    send_req(ReqObserve, '0, -8'sd128);
    send_req(ReqObserve, '0, -8'sd1);
    send_req(ReqObserve, '1, 8'sd0);
    send_req(ReqObserve, name_key, 8'sd5);
    send_req(ReqObserve, '1, 8'sd127);
    send_req(ReqFlush, '1, 8'sd127);
    send_req(ReqFlush, '0, '0);
    send_req(ReqObserve, name_key, -8'sd60);
    send_req(ReqFlush, '0, '0);
    drain();

    // back-pressure: receiver holds off while the sender keeps offering, so a flush
    // parks in the output register and the request side stalls behind it
    random_sent = 0;
    steady = 1'b1;
    hold_request = 1'b1;
    repeat (10) observe(rand_key(), rand_level());
    flush();
    repeat (10) observe(rand_key(), rand_level());
    flush();
    repeat (5) observe(rand_key(), rand_level());
    steady = 1'b0;
    drain();

    // random rounds, the first one overfills the table
    fill_round();
    while (random_sent < RandomItems) begin
      steady = ($urandom_range(0, 3) == 0);
      pick   = $urandom_range(0, 11);
      case (pick)
        0: fill_round();
        1: begin
          flush();
          flush();
        end
        2: repeat ($urandom_range(1, 6)) observe(rand_key(), rand_level());
        3: drain();
        4: pool_round(1'b0);
        default: pool_round(1'b1);
      endcase
    end
    flush();

    drain();
    repeat (DrainCycles) @(posedge clk);

    $display("ran %0d observations: %0d new peers, %0d raised, %0d kept, %0d dropped on full",
             sb.observations, sb.added, sb.raised, sb.kept, sb.dropped);
    $display("ran %0d flushes (%0d of an empty table), %0d result beats compared",
             sb.flushes, sb.empty_flushes, sb.beats_checked);
    if (sb.errors == 0) begin
      $display("peer_max_rssi_dedup_table test passed");
    end else begin
      $display("peer_max_rssi_dedup_table test failed");
    end
    $finish;
  end

endmodule
